[rtl/svp_pkg.sv]
// ----------------------------------------------------------------------------
// svp_pkg: shared types and constants of the shape vector plotter
// Register indexes, field widths, controller states, command and status.
// ----------------------------------------------------------------------------
package svp_pkg;

	localparam int unsigned SCALE_MAX_DEF = 32;
	localparam int unsigned SCREEN_W_DEF  = 280;
	localparam int unsigned SCREEN_H_DEF  = 192;

	// results per byte are capped here
	localparam int unsigned MAX_OUT = 64;
	localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PEN_W  = 16;
	localparam int unsigned X_W    = 9;
	localparam int unsigned Y_W    = 8;
	localparam int unsigned ROT_W  = 8;
	localparam int unsigned SCL_W  = 6;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned DATA_W = 9;

	typedef enum logic [IDX_W-1:0] {
		REG_START_X  = 3'd0,
		REG_START_Y  = 3'd1,
		REG_ROTATION = 3'd2,
		REG_SCALE    = 3'd3,
		REG_XOR_DRAW = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		SEC_A,
		SEC_B,
		SEC_C
	} sec_t;

	typedef enum logic [1:0] {
		MOVE_UP    = 2'd0,
		MOVE_RIGHT = 2'd1,
		MOVE_DOWN  = 2'd2,
		MOVE_LEFT  = 2'd3
	} dir_t;

	typedef struct packed {
		logic load;
		logic step;
		logic push_last;
		logic push_done;
	} svp_cmd_t;

	typedef struct packed {
		logic zero;
		logic emit;
		logic pend_v;
		logic slot_free;
		logic sec_end;
		logic more_sec;
	} svp_sts_t;

endpackage

[rtl/svp_if.sv]
// ----------------------------------------------------------------------------
// svp_if: request channels of the shape vector plotter
// Input channel carries definition bytes, output channel carries pixels.
// ----------------------------------------------------------------------------
interface svp_in_if;
	import svp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] shape_byte;

	modport source (output valid, output shape_byte, input ready);
	modport sink   (input valid, input shape_byte, output ready);
endinterface

interface svp_out_if;
	import svp_pkg::*;

	logic           valid;
	logic           ready;
	logic [X_W-1:0] pixel_x;
	logic [Y_W-1:0] pixel_y;
	logic           toggle;
	logic           shape_done;
	logic           last;

	modport source (output valid, output pixel_x, output pixel_y, output toggle,
		output shape_done, output last, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, input toggle,
		input shape_done, input last, output ready);
endinterface

[rtl/shape_vector_plotter.sv]
// ----------------------------------------------------------------------------
// shape_vector_plotter: vector shape drawing from definition bytes
// A byte is taken in the idle state, then the pen steps one section repeat at a time
// (up to 3 * SCALE_MAX repeats), then the flush state releases the final pixel.
// A new byte is taken only after the previous one is through the repeat loop
// of the single pen stepper and its flush; steps wait while the output stalls.
// Reset: registers take their reset values, pen at 0,0, no request held.
// ----------------------------------------------------------------------------
module shape_vector_plotter #(
	parameter int unsigned SCALE_MAX     = svp_pkg::SCALE_MAX_DEF,
	parameter int unsigned SCREEN_WIDTH  = svp_pkg::SCREEN_W_DEF,
	parameter int unsigned SCREEN_HEIGHT = svp_pkg::SCREEN_H_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [svp_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [svp_pkg::DATA_W-1:0] cfg_data,
	svp_in_if.sink                     in_ch,
	svp_out_if.source                  out_ch
);
	import svp_pkg::*;

	svp_cmd_t cmd;
	svp_sts_t sts;
	logic     in_ready;

	assign in_ch.ready = in_ready;

	svp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	svp_datapath #(
		.SCALE_MAX     (SCALE_MAX),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.shape_byte (in_ch.shape_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_ch     (out_ch)
	);

endmodule

[rtl/svp_datapath.sv]
// ----------------------------------------------------------------------------
// svp_datapath: pen, section sequencing and result registers
// Holds the configuration, steps the pen one repeat per command, keeps one
// pending pixel so the last flag can be set, and drives the output register.
// ----------------------------------------------------------------------------
module svp_datapath #(
	parameter int unsigned SCALE_MAX     = svp_pkg::SCALE_MAX_DEF,
	parameter int unsigned SCREEN_WIDTH  = svp_pkg::SCREEN_W_DEF,
	parameter int unsigned SCREEN_HEIGHT = svp_pkg::SCREEN_H_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [svp_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [svp_pkg::DATA_W-1:0]  cfg_data,
	input  logic [svp_pkg::BYTE_W-1:0]  shape_byte,
	input  svp_pkg::svp_cmd_t           cmd,
	output svp_pkg::svp_sts_t           sts,
	svp_out_if.source                   out_ch
);
	import svp_pkg::*;

	localparam int unsigned REP_W = (SCALE_MAX > 1) ? $clog2(SCALE_MAX) : 1;

	logic [X_W-1:0]    start_x_q;
	logic [Y_W-1:0]    start_y_q;
	logic [ROT_W-1:0]  rot_q;
	logic [SCL_W-1:0]  scale_q;
	logic              xor_q;
	logic [PEN_W-1:0]  pen_x_q;
	logic [PEN_W-1:0]  pen_y_q;
	logic [BYTE_W-1:0] byte_q;
	sec_t              sec_q;
	logic [REP_W-1:0]  rep_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_v_q;
	logic [X_W-1:0]    pend_x_q;
	logic [Y_W-1:0]    pend_y_q;
	logic              pend_t_q;
	logic              ovalid_q;
	logic [X_W-1:0]    ox_q;
	logic [Y_W-1:0]    oy_q;
	logic              ot_q;
	logic              odone_q;
	logic              olast_q;

	logic [REP_W-1:0]  reps_m1;
	logic [6:0]        rot_sum;
	logic [1:0]        quad;
	logic [1:0]        raw_dir;
	dir_t              dir;
	logic              plot;
	logic              more_sec;
	logic              on_screen;
	logic              emit;
	logic              push_pend;
	logic              slot_free;

	// repeat count minus one, scale clamped to 1..SCALE_MAX
	always_comb begin
		if (scale_q == '0) begin
			reps_m1 = '0;
		end else if (int'(scale_q) > int'(SCALE_MAX)) begin
			reps_m1 = REP_W'(SCALE_MAX - 1);
		end else begin
			reps_m1 = REP_W'(scale_q - SCL_W'(1));
		end
	end

	assign rot_sum = {1'b0, rot_q[5:0]} + 7'd8;
	assign quad    = rot_sum[5:4];

	always_comb begin
		case (sec_q)
			SEC_A: begin
				raw_dir  = byte_q[1:0];
				plot     = byte_q[2];
				more_sec = byte_q[7:3] != '0;
			end
			SEC_B: begin
				raw_dir  = byte_q[4:3];
				plot     = byte_q[5];
				more_sec = byte_q[7:6] != '0;
			end
			default: begin
				raw_dir  = byte_q[7:6];
				plot     = 1'b0;
				more_sec = 1'b0;
			end
		endcase
	end

	assign dir = dir_t'(raw_dir + quad);

	assign on_screen = !pen_x_q[PEN_W-1] && (pen_x_q < PEN_W'(SCREEN_WIDTH)) &&
		!pen_y_q[PEN_W-1] && (pen_y_q < PEN_W'(SCREEN_HEIGHT));
	assign emit      = plot && on_screen && (cnt_q < CNT_W'(MAX_OUT));
	assign slot_free = !ovalid_q || out_ch.ready;
	assign push_pend = cmd.step && emit && pend_v_q;

	assign sts.zero      = byte_q == '0;
	assign sts.emit      = emit;
	assign sts.pend_v    = pend_v_q;
	assign sts.slot_free = slot_free;
	assign sts.sec_end   = rep_q == reps_m1;
	assign sts.more_sec  = more_sec;

	// configuration and pen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			rot_q     <= '0;
			scale_q   <= SCL_W'(1);
			xor_q     <= 1'b0;
			pen_x_q   <= '0;
			pen_y_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_START_X: begin
						start_x_q <= cfg_data[X_W-1:0];
						pen_x_q   <= PEN_W'(cfg_data[X_W-1:0]);
					end
					REG_START_Y: begin
						start_y_q <= cfg_data[Y_W-1:0];
						pen_y_q   <= PEN_W'(cfg_data[Y_W-1:0]);
					end
					REG_ROTATION: rot_q   <= cfg_data[ROT_W-1:0];
					REG_SCALE:    scale_q <= cfg_data[SCL_W-1:0];
					REG_XOR_DRAW: xor_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.push_done) begin
				pen_x_q <= PEN_W'(start_x_q);
				pen_y_q <= PEN_W'(start_y_q);
			end else if (cmd.step) begin
				case (dir)
					MOVE_UP:    pen_y_q <= pen_y_q - PEN_W'(1);
					MOVE_RIGHT: pen_x_q <= pen_x_q + PEN_W'(1);
					MOVE_DOWN:  pen_y_q <= pen_y_q + PEN_W'(1);
					default:    pen_x_q <= pen_x_q - PEN_W'(1);
				endcase
			end
		end
	end

	// sequencing and pending pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q    <= SEC_A;
			rep_q    <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				sec_q    <= SEC_A;
				rep_q    <= '0;
				cnt_q    <= '0;
				pend_v_q <= 1'b0;
			end else if (cmd.step) begin
				if (emit) begin
					pend_v_q <= 1'b1;
					cnt_q    <= cnt_q + CNT_W'(1);
				end
				if (rep_q == reps_m1) begin
					rep_q <= '0;
					case (sec_q)
						SEC_A:   sec_q <= SEC_B;
						default: sec_q <= SEC_C;
					endcase
				end else begin
					rep_q <= rep_q + REP_W'(1);
				end
			end else if (cmd.push_last) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= shape_byte;
		end
		if (cmd.step && emit) begin
			pend_x_q <= pen_x_q[X_W-1:0];
			pend_y_q <= pen_y_q[Y_W-1:0];
			pend_t_q <= xor_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (push_pend || cmd.push_last || cmd.push_done) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_done) begin
			ox_q    <= '0;
			oy_q    <= '0;
			ot_q    <= 1'b0;
			odone_q <= 1'b1;
			olast_q <= 1'b1;
		end else if (push_pend || cmd.push_last) begin
			ox_q    <= pend_x_q;
			oy_q    <= pend_y_q;
			ot_q    <= pend_t_q;
			odone_q <= 1'b0;
			olast_q <= cmd.push_last;
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.pixel_x    = ox_q;
	assign out_ch.pixel_y    = oy_q;
	assign out_ch.toggle     = ot_q;
	assign out_ch.shape_done = odone_q;
	assign out_ch.last       = olast_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OUT))
		else $error("result count past cap");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(push_pend || cmd.push_last || cmd.push_done) |-> slot_free)
		else $error("output register overwritten while held");

endmodule

[rtl/svp_ctrl.sv]
// ----------------------------------------------------------------------------
// svp_ctrl: sequencing state machine of the shape vector plotter
// Takes a byte, steps the datapath one repeat a cycle while the output slot
// allows, flushes the pending pixel with its last flag, and handles the end-of-shape byte.
// ----------------------------------------------------------------------------
module svp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  svp_pkg::svp_sts_t sts,
	output svp_pkg::svp_cmd_t cmd
);
	import svp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.zero) begin
					if (sts.slot_free) begin
						cmd.push_done = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (!(sts.emit && sts.pend_v && !sts.slot_free)) begin
					cmd.step = 1'b1;
					if (sts.sec_end && !sts.more_sec) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_v) begin
					state_d = ST_IDLE;
				end else if (sts.slot_free) begin
					cmd.push_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.push_last, cmd.push_done}))
		else $error("conflicting datapath commands");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && state_d == ST_IDLE) |=> !sts.pend_v)
		else $error("pending pixel left after flush");

endmodule
